// ----- hw/rtl/oahs_pkg.sv -----
// shared types and constants of the open-address hash set
// no dependencies; imported by every module of the block except oahs_ram
package oahs_pkg;

  localparam int IN_KEY_W  = 32;  // key field width on the item beat
  localparam int COUNT_W   = 11;  // live and filled counters
  localparam int MEMBER_W  = 10;  // member_count field width
  localparam int MARK_W    = 2;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_DELETE = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  typedef enum logic [MARK_W-1:0] {
    MARK_EMPTY = 2'd0,
    MARK_LIVE  = 2'd1,
    MARK_TOMB  = 2'd2
  } mark_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    logic [1:0]          operation;
    logic [IN_KEY_W-1:0] key;
  } item_t;

  typedef struct packed {
    logic                success;
    logic                table_full;
    logic [MEMBER_W-1:0] member_count;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic clear_en;
    logic load;
    logic eval;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic item_nop;
    logic probe_end;
  } stat_t;

endpackage

// ----- hw/rtl/oahs_ram.sv -----
// generic single-write, single-read memory with registered read data
// no dependencies
module oahs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/oahs_ctrl.sv -----
// sequencing state machine of the hash set: clear sweep, probe loop, commit
// depends on oahs_pkg
module oahs_ctrl
  import oahs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);

  state_e state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (stat.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = stat.item_nop ? ST_COMMIT : ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = stat.probe_end ? ST_COMMIT : ST_READ;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// ----- hw/rtl/oahs_dp.sv -----
// datapath of the hash set: slot memories, probe sequence, counters, result register
// depends on oahs_pkg and oahs_ram
module oahs_dp
  import oahs_pkg::*;
#(
  parameter int CAPACITY    = 1024,
  parameter int PROBE_SHIFT = 5,
  parameter int KEY_WIDTH   = 32
) (
  input  logic    clk,
  input  logic    rst,
  input  item_t   item,
  input  cmd_t    cmd,
  output stat_t   stat,
  output result_t result,
  output logic    done
);

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int LIMIT  = CAPACITY + KEY_WIDTH;
  localparam int STEP_W = $clog2(LIMIT + 1);
  localparam int CMP_W  = (SLOT_W + 1 > COUNT_W + 1) ? SLOT_W + 1 : COUNT_W + 1;

  logic [1:0]           op;
  logic [KEY_WIDTH-1:0] key;
  logic [KEY_WIDTH-1:0] perturb;
  logic [SLOT_W-1:0]    idx;
  logic [STEP_W-1:0]    step;
  logic                 found;
  logic                 have_empty;
  logic                 tomb_seen;
  logic [SLOT_W-1:0]    hit_slot;
  logic [SLOT_W-1:0]    empty_slot;
  logic [SLOT_W-1:0]    tomb_slot;
  logic [COUNT_W-1:0]   live_count;
  logic [COUNT_W-1:0]   filled_count;
  logic [SLOT_W-1:0]    clear_addr;

  logic [KEY_WIDTH-1:0] key_eff;
  logic [KEY_WIDTH-1:0] perturb_adv;
  logic [SLOT_W-1:0]    idx_next;
  logic [MARK_W-1:0]    rd_mark;
  logic [KEY_WIDTH-1:0] rd_key;
  logic                 is_live;
  logic                 is_tomb;
  logic                 is_empty;
  logic                 hit;
  logic                 room;

  logic                 succ_c;
  logic                 full_c;
  logic [COUNT_W-1:0]   live_next;
  logic [COUNT_W-1:0]   filled_next;
  logic                 wr_mark_en;
  logic                 wr_key_en;
  logic [SLOT_W-1:0]    wr_slot;
  logic [MARK_W-1:0]    wr_mark;

  logic                 mark_we;
  logic [SLOT_W-1:0]    mark_waddr;
  logic [MARK_W-1:0]    mark_wdata;

  assign key_eff     = KEY_WIDTH'(item.key);
  assign perturb_adv = perturb >> PROBE_SHIFT;
  // i*5 + 1 + perturb, wrapped to the table
  assign idx_next    = idx + {idx[SLOT_W-3:0], 2'b00} + SLOT_W'(1) + SLOT_W'(perturb_adv);

  // slot memories, both read at the current probe slot
  assign mark_we    = cmd.clear_en | (cmd.commit & wr_mark_en);
  assign mark_waddr = cmd.clear_en ? clear_addr : wr_slot;
  assign mark_wdata = cmd.clear_en ? MARK_EMPTY : wr_mark;

  oahs_ram #(.WIDTH(MARK_W), .DEPTH(CAPACITY)) u_mark_ram (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .raddr (idx),
    .rdata (rd_mark)
  );

  oahs_ram #(.WIDTH(KEY_WIDTH), .DEPTH(CAPACITY)) u_key_ram (
    .clk   (clk),
    .we    (cmd.commit & wr_key_en),
    .waddr (wr_slot),
    .wdata (key),
    .raddr (idx),
    .rdata (rd_key)
  );

  // unused mark code reads as empty
  assign is_live  = (rd_mark == MARK_LIVE);
  assign is_tomb  = (rd_mark == MARK_TOMB);
  assign is_empty = !is_live && !is_tomb;
  assign hit      = is_live && (rd_key == key);

  assign stat.clear_last = (clear_addr == SLOT_W'(CAPACITY - 1));
  assign stat.item_nop   = (item.operation != OP_ADD) && (item.operation != OP_DELETE)
                           && (item.operation != OP_QUERY);
  assign stat.probe_end  = hit || is_empty || (step == STEP_W'(LIMIT - 1));

  assign room = (CMP_W'(filled_count) + CMP_W'(1)) < CMP_W'(CAPACITY);

  always_comb begin
    succ_c      = 1'b0;
    full_c      = 1'b0;
    live_next   = live_count;
    filled_next = filled_count;
    wr_mark_en  = 1'b0;
    wr_key_en   = 1'b0;
    wr_slot     = hit_slot;
    wr_mark     = MARK_LIVE;
    case (op)
      OP_ADD: begin
        if (!found) begin
          if (tomb_seen) begin
            wr_slot    = tomb_slot;
            wr_mark_en = 1'b1;
            wr_key_en  = 1'b1;
            live_next  = live_count + COUNT_W'(1);
            succ_c     = 1'b1;
          end else if (have_empty && room) begin
            wr_slot     = empty_slot;
            wr_mark_en  = 1'b1;
            wr_key_en   = 1'b1;
            live_next   = live_count + COUNT_W'(1);
            filled_next = filled_count + COUNT_W'(1);
            succ_c      = 1'b1;
          end else begin
            full_c = 1'b1;
          end
        end
      end
      OP_DELETE: begin
        if (found) begin
          wr_mark    = MARK_TOMB;
          wr_mark_en = 1'b1;
          live_next  = live_count - COUNT_W'(1);
          succ_c     = 1'b1;
        end
      end
      OP_QUERY: begin
        succ_c = found;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr   <= '0;
      live_count   <= '0;
      filled_count <= '0;
      done         <= 1'b0;
      found        <= 1'b0;
      have_empty   <= 1'b0;
      tomb_seen    <= 1'b0;
      step         <= '0;
    end else begin
      done <= cmd.commit;
      if (cmd.clear_en) begin
        clear_addr <= clear_addr + SLOT_W'(1);
      end
      if (cmd.load) begin
        op         <= item.operation;
        key        <= key_eff;
        perturb    <= key_eff;
        idx        <= SLOT_W'(key_eff);
        step       <= '0;
        found      <= 1'b0;
        have_empty <= 1'b0;
        tomb_seen  <= 1'b0;
      end
      if (cmd.eval) begin
        step    <= step + STEP_W'(1);
        perturb <= perturb_adv;
        idx     <= idx_next;
        if (hit) begin
          found    <= 1'b1;
          hit_slot <= idx;
        end
        if (is_empty) begin
          have_empty <= 1'b1;
          empty_slot <= idx;
        end
        if (is_tomb && !tomb_seen) begin
          tomb_seen <= 1'b1;
          tomb_slot <= idx;
        end
      end
      if (cmd.commit) begin
        live_count          <= live_next;
        filled_count        <= filled_next;
        result.success      <= succ_c;
        result.table_full   <= full_c;
        result.member_count <= live_next[MEMBER_W-1:0];
      end
    end
  end

endmodule

// ----- hw/rtl/open_address_hash_set_core.sv -----
// top level of the open-address hash set
// depends on oahs_pkg, oahs_ctrl, oahs_dp (which holds two oahs_ram instances)
//
// usage
//   - item beat: drive item (operation, key) with start; it is taken at the
//     rising edge where start is high and busy is low
//   - operations: add, delete, query membership; the unused code changes
//     nothing and answers success 0, table_full 0
//   - result beat: done is high for exactly one cycle with result
//     (success, table_full, member_count); the receiver cannot stall it
//   - each probe step is one read of the slot memories: an address state
//     (ST_READ), then compare and next-slot calculation (ST_EVAL)
//   - commit: after the last probe step the commit state updates the
//     counters and the result register, and done is registered from it
//   - the unused code skips the probe and goes straight to commit; one item
//     at a time, busy stays high until the block is back in idle
//   - reset: synchronous, active high; afterwards the mark memory is swept
//     to empty, one slot per cycle, with busy held high until the last slot
//   - key memory is never cleared; its read data is only used behind a live mark
//   - counters wrap at 11 bits; member_count shows the low 10
module open_address_hash_set_core
  import oahs_pkg::*;
#(
  parameter int CAPACITY    = 1024,
  parameter int PROBE_SHIFT = 5,
  parameter int KEY_WIDTH   = 32
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  item_t   item,
  output logic    busy,
  output logic    done,
  output result_t result
);

  cmd_t  cmd;
  stat_t stat;

  // sequencing only; all slot state and arithmetic lives in the datapath
  oahs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // probe address generation, slot memories, counters and result register
  oahs_dp #(
    .CAPACITY    (CAPACITY),
    .PROBE_SHIFT (PROBE_SHIFT),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .stat   (stat),
    .result (result),
    .done   (done)
  );

endmodule

// ----- hw/rtl/oahs_checker.sv -----
// port-level checks for the hash set top level, attached by bind
// depends on oahs_pkg and open_address_hash_set_core
module oahs_checker
  import oahs_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input item_t   item,
  input logic    busy,
  input logic    done,
  input result_t result
);

  // clearing sweep holds the block busy straight after reset
  a_busy_after_rst: assert property (@(posedge clk) $past(rst) |-> busy)
    else $error("block not busy after reset");

  // a taken beat makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("no busy after item beat");

  // one item at a time, so results never come on adjacent cycles
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result beats on adjacent cycles");

  // a refused add never reports success
  a_full_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.success && result.table_full))
    else $error("success and table_full together");

endmodule

bind open_address_hash_set_core oahs_checker u_oahs_checker (.*);

// ----- tb/tb_top.sv -----
// self-checking testbench for open_address_hash_set_core
// depends on oahs_pkg and the core; keeps a shadow copy of the slot table to predict results
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import oahs_pkg::*;

  localparam int SLOTS       = 1024;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int PROBE_SHIFT = 5;
  localparam int KEY_W       = 32;
  localparam int PROBE_LIMIT = SLOTS + KEY_W;

  // operation code the block leaves unused
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [KEY_W-1:0] key;
    logic             typed;  // row carries its own expected result
    result_t          res;
  } stim_row_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  item_t   item = '0;
  logic    busy;
  logic    done;
  result_t result;

  // shadow of the slot table
  logic [KEY_W-1:0]   shadow_key [SLOTS];
  mark_e              shadow_mark [SLOTS];
  logic [COUNT_W-1:0] shadow_live = '0;
  logic [COUNT_W-1:0] shadow_filled = '0;

  result_t            pending_results [$];
  logic [KEY_W-1:0]   recent_keys [$];
  stim_row_t          directed_rows [$];
  int                 mismatch_count = 0;
  int                 idle_pct = 0;

  open_address_hash_set_core #(
    .CAPACITY   (SLOTS),
    .PROBE_SHIFT(PROBE_SHIFT),
    .KEY_WIDTH  (KEY_W)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (item),
    .busy  (busy),
    .done  (done),
    .result(result)
  );

  always #5 clk = ~clk;

  // walk the probe sequence over the shadow table, apply the operation, return the answer
  function automatic result_t hash_set_apply(input logic [1:0] op, input logic [KEY_W-1:0] key);
    logic [SLOT_W-1:0] idx;
    logic [SLOT_W-1:0] hit_idx;
    logic [SLOT_W-1:0] tomb_idx;
    logic [SLOT_W-1:0] empty_idx;
    logic [KEY_W-1:0]  perturb;
    logic              found;
    logic              have_tomb;
    logic              have_empty;
    logic              stop;
    int                step;
    result_t           r;
    idx = key[SLOT_W-1:0];
    perturb = key;
    found = 1'b0;
    have_tomb = 1'b0;
    have_empty = 1'b0;
    stop = 1'b0;
    hit_idx = '0;
    tomb_idx = '0;
    empty_idx = '0;
    step = 0;
    while (!stop && step < PROBE_LIMIT) begin
      if (shadow_mark[idx] == MARK_LIVE) begin
        if (shadow_key[idx] == key) begin
          found = 1'b1;
          hit_idx = idx;
          stop = 1'b1;
        end
      end else if (shadow_mark[idx] == MARK_TOMB) begin
        // keep going past tombstones, remember the first one
        if (!have_tomb) begin
          have_tomb = 1'b1;
          tomb_idx = idx;
        end
      end else begin
        have_empty = 1'b1;
        empty_idx = idx;
        stop = 1'b1;
      end
      if (!stop) begin
        perturb = perturb >> PROBE_SHIFT;
        idx = SLOT_W'(idx * 5 + 1 + perturb[SLOT_W-1:0]);
      end
      step++;
    end

    r = '0;
    case (op)
      OP_ADD: begin
        if (!found) begin
          if (have_tomb) begin
            shadow_key[tomb_idx] = key;
            shadow_mark[tomb_idx] = MARK_LIVE;
            shadow_live = shadow_live + 1'b1;
            r.success = 1'b1;
          end else if (have_empty && int'(shadow_filled) + 1 < SLOTS) begin
            shadow_key[empty_idx] = key;
            shadow_mark[empty_idx] = MARK_LIVE;
            shadow_live = shadow_live + 1'b1;
            shadow_filled = shadow_filled + 1'b1;
            r.success = 1'b1;
          end else begin
            r.table_full = 1'b1;
          end
        end
      end
      OP_DELETE: begin
        if (found) begin
          shadow_mark[hit_idx] = MARK_TOMB;
          shadow_live = shadow_live - 1'b1;
          r.success = 1'b1;
        end
      end
      OP_QUERY: r.success = found;
      default: ;
    endcase
    r.member_count = shadow_live[MEMBER_W-1:0];
    return r;
  endfunction

  // keys that crowd a few slots, keys seen lately, or anything at all
  function automatic logic [KEY_W-1:0] random_key();
    logic [KEY_W-1:0] k;
    k = $urandom;
    case ($urandom_range(0, 3))
      0: ;
      1: k = ($urandom_range(0, 31) << SLOT_W) | $urandom_range(0, 7);
      2: begin
        k[3:0] = 4'($urandom_range(0, 15));
        k[SLOT_W-1:4] = '1;
      end
      default: begin
        if (recent_keys.size() != 0) k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
      end
    endcase
    return k;
  endfunction

  // a key that is live in the shadow table, when one turns up quickly
  function automatic logic [KEY_W-1:0] live_key();
    int slot;
    for (int tries = 0; tries < 64; tries++) begin
      slot = $urandom_range(0, SLOTS - 1);
      if (shadow_mark[slot] == MARK_LIVE) return shadow_key[slot];
    end
    return random_key();
  endfunction

  task automatic add_row(input logic [1:0] op, input logic [KEY_W-1:0] key, input logic typed,
                         input logic s, input logic f, input logic [MEMBER_W-1:0] cnt);
    stim_row_t row;
    row.op = op;
    row.key = key;
    row.typed = typed;
    row.res.success = s;
    row.res.table_full = f;
    row.res.member_count = cnt;
    directed_rows.push_back(row);
  endtask

  // present one item beat and hold it until the block takes it
  task automatic send_item(input logic [1:0] op, input logic [KEY_W-1:0] key,
                           input logic typed, input result_t want);
    result_t predicted;
    @(negedge clk);
    start <= 1'b1;
    item <= {op, key};
    do @(posedge clk); while (busy);
    predicted = hash_set_apply(op, key);
    pending_results.push_back(typed ? want : predicted);
    recent_keys.push_back(key);
    if (recent_keys.size() > 48) void'(recent_keys.pop_front());
  endtask

  task automatic hold_off(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic send_mixed();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) send_item(OP_ADD, random_key(), 1'b0, '0);
    else if (r < 70) send_item(OP_DELETE, ($urandom_range(0, 9) < 7) ? live_key() : random_key(),
                               1'b0, '0);
    else if (r < 95) send_item(OP_QUERY, $urandom_range(0, 1) ? live_key() : random_key(),
                               1'b0, '0);
    else send_item(OP_UNUSED, $urandom, 1'b0, '0);
    if ($urandom_range(0, 99) < idle_pct) hold_off($urandom_range(1, 16));
  endtask

  // result beats cannot be held off, so every done is checked on the edge it ends
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, got success %b full %b count %0d",
                 $time, result.success, result.table_full, result.member_count);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (result.success !== want.success || result.table_full !== want.table_full ||
            result.member_count !== want.member_count) begin
          $display("%0t: mismatch, expected success %b full %b count %0d, got %b %b %0d",
                   $time, want.success, want.table_full, want.member_count,
                   result.success, result.table_full, result.member_count);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : stimulus
    int r;
    for (int s = 0; s < SLOTS; s++) begin
      shadow_key[s] = '0;
      shadow_mark[s] = MARK_EMPTY;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty table, extreme keys, duplicates, colliding keys and tombstone reuse
    add_row(OP_QUERY,  32'h0000_0000, 1'b1, 1'b0, 1'b0, 10'd0);
    add_row(OP_DELETE, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 10'd0);
    add_row(OP_UNUSED, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 10'd0);
    add_row(OP_ADD,    32'h0000_0000, 1'b1, 1'b1, 1'b0, 10'd1);
    add_row(OP_ADD,    32'h0000_0000, 1'b1, 1'b0, 1'b0, 10'd1);
    add_row(OP_ADD,    32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 10'd2);
    add_row(OP_ADD,    32'h0000_0400, 1'b0, 1'b0, 1'b0, 10'd0);
    add_row(OP_ADD,    32'h0000_0800, 1'b0, 1'b0, 1'b0, 10'd0);
    add_row(OP_QUERY,  32'h0000_0400, 1'b0, 1'b0, 1'b0, 10'd0);
    add_row(OP_DELETE, 32'h0000_0000, 1'b1, 1'b1, 1'b0, 10'd3);
    add_row(OP_QUERY,  32'h0000_0800, 1'b0, 1'b0, 1'b0, 10'd0);
    add_row(OP_QUERY,  32'h0000_0000, 1'b1, 1'b0, 1'b0, 10'd3);
    add_row(OP_ADD,    32'h0000_0C00, 1'b0, 1'b0, 1'b0, 10'd0);
    add_row(OP_QUERY,  32'h0000_0C00, 1'b0, 1'b0, 1'b0, 10'd0);
    add_row(OP_DELETE, 32'h0000_0400, 1'b0, 1'b0, 1'b0, 10'd0);
    add_row(OP_DELETE, 32'h0000_0400, 1'b0, 1'b0, 1'b0, 10'd0);
    add_row(OP_ADD,    32'h0000_0400, 1'b0, 1'b0, 1'b0, 10'd0);
    add_row(OP_UNUSED, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 10'd0);
    add_row(OP_QUERY,  32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 10'd0);
    add_row(OP_DELETE, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 10'd0);
    add_row(OP_ADD,    32'h8000_0000, 1'b0, 1'b0, 1'b0, 10'd0);
    add_row(OP_ADD,    32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 10'd0);
    add_row(OP_ADD,    32'hAAAA_AAAA, 1'b0, 1'b0, 1'b0, 10'd0);
    add_row(OP_ADD,    32'h5555_5555, 1'b0, 1'b0, 1'b0, 10'd0);

    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].key, directed_rows[i].typed,
                directed_rows[i].res);
    wait_all_results();

    // mixed traffic, light then heavy sender gaps
    for (int ph = 0; ph < 2; ph++) begin
      idle_pct = (ph == 0) ? 22 : 48;
      repeat (280) send_mixed();
      wait_all_results();
    end

    // back to back: fill until a single empty slot is left
    idle_pct = 0;
    while (int'(shadow_filled) < SLOTS - 1) send_item(OP_ADD, $urandom, 1'b0, '0);

    // table at its limit: refused adds, tombstones and their reuse, long probes
    repeat (120) begin
      r = $urandom_range(0, 99);
      if (r < 40) send_item(OP_ADD, $urandom, 1'b0, '0);
      else if (r < 70) send_item(OP_DELETE, live_key(), 1'b0, '0);
      else if (r < 90) send_item(OP_QUERY, $urandom_range(0, 1) ? live_key() : $urandom,
                                 1'b0, '0);
      else send_item(OP_ADD, live_key(), 1'b0, '0);
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("open_address_hash_set_core test passed");
    end else begin
      $display("open_address_hash_set_core test failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #150ms;
    $display("open_address_hash_set_core test failed");
    $finish;
  end

endmodule
